@@ src/reversible_deque_engine_macros.svh @@
// ---------------------------------------------------------------------------
// reversible_deque_engine_macros
// Assertion macros shared by the deque engine RTL.
// ---------------------------------------------------------------------------
`ifndef REVERSIBLE_DEQUE_ENGINE_MACROS_SVH
`define REVERSIBLE_DEQUE_ENGINE_MACROS_SVH

// check a condition in the same cycle as its trigger, on clock and reset in scope
`define RDE_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// check a condition in the cycle after its trigger, on clock and reset in scope
`define RDE_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ src/rde_pkg.sv @@
// ---------------------------------------------------------------------------
// rde_pkg
// Types and constants of the reversible deque engine.
// ---------------------------------------------------------------------------
package rde_pkg;

   localparam int DEPTH_DEFAULT      = 1024;
   localparam int DATA_WIDTH_DEFAULT = 16;

   localparam int MODE_W  = 3;
   localparam int VALUE_W = 16;
   localparam int OCC_W   = 11;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_RIGHT = 3'd0,
      MODE_PUSH_LEFT  = 3'd1,
      MODE_TOGGLE     = 3'd2,
      MODE_DROP_FRONT = 3'd3,
      MODE_TAKE_FRONT = 3'd4,
      MODE_CLEAR      = 3'd5
   } mode_type;

endpackage

@@ src/rde_ram.sv @@
// ---------------------------------------------------------------------------
// rde_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rde_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/reversible_deque_engine.sv @@
// ---------------------------------------------------------------------------
// reversible_deque_engine
// Result: registered, presented in the cycle after the request is accepted.
// Throughput: one operation per cycle while rsp_tready is high; the result
// register and RAM read port set the pace; each touches at most one entry.
// Reset: synchronous; empties the queue, clears reverse and error at once.
// ---------------------------------------------------------------------------
`include "reversible_deque_engine_macros.svh"

module reversible_deque_engine #(
   parameter int DEPTH      = rde_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = rde_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // mode[2:0], value[18:3], zero fill
   input  logic [rde_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // data_out[15:0], data_valid[16], queue_empty[17], error_flag[18],
   // overflow[19], occupancy[30:20], zero fill
   output logic [rde_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import rde_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW:0]   DEPTH_C = (AW+1)'(DEPTH);
   localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

   logic [AW-1:0] left_ff, left_in;
   logic [AW:0]   count_ff, count_in;
   logic          rev_ff, rev_in;
   logic          err_ff, err_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             take_ff;
   logic             empty_ff;
   logic             error_ff;
   logic             ovf_ff;
   logic [OCC_W-1:0] occ_ff;

   logic                  accept;
   logic                  clear_op;
   mode_type              mode;
   logic [VALUE_W-1:0]    value;
   logic                  full;
   logic                  empty;
   logic [AW:0]           tail_sum, last_sum;
   logic [AW-1:0]         tail_idx, last_idx, left_dec, left_inc;
   logic                  take;
   logic                  ovf;
   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [VALUE_W-1:0]    rd_value;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign mode       = mode_type'(req_tdata[MODE_W-1:0]);
   assign value      = req_tdata[MODE_W +: VALUE_W];
   assign clear_op   = accept && (mode == MODE_CLEAR);

   assign full  = (count_ff == DEPTH_C);
   assign empty = (count_ff == '0);

   assign tail_sum = {1'b0, left_ff} + count_ff;
   assign last_sum = tail_sum - (AW+1)'(1);
   assign tail_idx = (tail_sum >= DEPTH_C) ? AW'(tail_sum - DEPTH_C) : tail_sum[AW-1:0];
   assign last_idx = (last_sum >= DEPTH_C) ? AW'(last_sum - DEPTH_C) : last_sum[AW-1:0];
   assign left_dec = (left_ff == '0) ? LAST_C : left_ff - AW'(1);
   assign left_inc = (left_ff == LAST_C) ? '0 : left_ff + AW'(1);

   always_comb begin
      left_in  = left_ff;
      count_in = count_ff;
      rev_in   = rev_ff;
      err_in   = err_ff;
      take     = 1'b0;
      ovf      = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      wr_addr  = tail_idx;
      rd_addr  = rev_ff ? last_idx : left_ff;
      if (accept) begin
         if (mode == MODE_CLEAR) begin
            left_in  = '0;
            count_in = '0;
            rev_in   = 1'b0;
            err_in   = 1'b0;
         end else if (!err_ff) begin
            case (mode)
               MODE_PUSH_RIGHT: begin
                  if (full) begin
                     ovf = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + (AW+1)'(1);
                  end
               end
               MODE_PUSH_LEFT: begin
                  if (full) begin
                     ovf = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = left_dec;
                     left_in  = left_dec;
                     count_in = count_ff + (AW+1)'(1);
                  end
               end
               MODE_TOGGLE: begin
                  rev_in = !rev_ff;
               end
               MODE_DROP_FRONT, MODE_TAKE_FRONT: begin
                  if (empty) begin
                     err_in = 1'b1;
                  end else begin
                     if (!rev_ff) begin
                        left_in = left_inc;
                     end
                     count_in = count_ff - (AW+1)'(1);
                     if (mode == MODE_TAKE_FRONT) begin
                        take  = 1'b1;
                        rd_en = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         take_ff  <= take;
         empty_ff <= (count_in == '0);
         error_ff <= err_in;
         ovf_ff   <= ovf;
         occ_ff   <= OCC_W'(count_in);
      end
   end

   rde_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (DATA_WIDTH'(value)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_value   = VALUE_W'(rd_data);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, occ_ff, ovf_ff, error_ff, empty_ff, take_ff,
                        (take_ff ? rd_value : {VALUE_W{1'b0}})};

   `RDE_ASSERT_SAME(a_count_range, 1'b1, count_ff <= DEPTH_C, "count exceeds depth")
   `RDE_ASSERT_SAME(a_take_no_error, rsp_valid_ff && take_ff, !error_ff, "take with error set")
   `RDE_ASSERT_SAME(a_ovf_full, rsp_valid_ff && ovf_ff, full, "overflow when not full")
   `RDE_ASSERT_NEXT(a_clear, clear_op, empty && !err_ff && !rev_ff, "clear did not empty")

endmodule
